FILE: hw/rtl/tlcd_pkg.sv
// Package for the tag-length chunk deframer: constants, status codes and word types.
package tlcd_pkg;

  // Section header layout: 4-byte tag then 4-byte length, both little endian
  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned FieldBytes  = 4;
  localparam int unsigned PosWidth    = $clog2(HeaderBytes);

  // End-of-stream status codes
  typedef enum logic [1:0] {
    StatusOk          = 2'd0,
    StatusTruncHeader = 2'd1,
    StatusPayloadOver = 2'd2
  } status_e;

  // One input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // One labelled output word
  typedef struct packed {
    logic [7:0]  byte_out;
    logic        is_payload;
    logic [31:0] section_tag;
    logic [31:0] payload_length;
    logic [31:0] payload_offset;
    logic        header_done;
    logic        section_end;
    logic [31:0] section_number;
    logic        stream_end;
    status_e     status;
  } out_word_t;

endpackage

FILE: hw/rtl/tlcd_if.sv
// Stream interfaces for the deframer: raw byte input and labelled byte output.
interface tlcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tlcd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic        is_payload;
  logic [31:0] section_tag;
  logic [31:0] payload_length;
  logic [31:0] payload_offset;
  logic        header_done;
  logic        section_end;
  logic [31:0] section_number;
  logic        stream_end;
  logic [1:0]  status;

  modport source (
    output valid, output byte_out, output is_payload, output section_tag,
    output payload_length, output payload_offset, output header_done,
    output section_end, output section_number, output stream_end, output status,
    input ready
  );
  modport sink (
    input valid, input byte_out, input is_payload, input section_tag,
    input payload_length, input payload_offset, input header_done,
    input section_end, input section_number, input stream_end, input status,
    output ready
  );
endinterface

FILE: hw/rtl/tlcd_parse.sv
// Section parser: header assembly, payload tracking and per-byte labelling.
module tlcd_parse import tlcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_word_t  word_i,
  output out_word_t word_o
);

  logic [PosWidth-1:0] pos_q, pos_d;
  logic                in_pay_q, in_pay_d;
  logic [31:0]         tag_q, tag_d;
  logic [31:0]         len_q, len_d;
  logic [31:0]         rem_q, rem_d;
  logic [31:0]         sec_q, sec_d;

  logic [31:0] tag_base, len_base;
  logic [4:0]  lane_sel;
  logic [31:0] sec_next;

  // Saturating section index
  assign sec_next = (sec_q == '1) ? sec_q : sec_q + 32'd1;
  // Byte lane inside the 32-bit field being assembled
  assign lane_sel = {pos_q[1:0], 3'b000};

  // Label the word and work out the next state
  always_comb begin
    pos_d    = pos_q;
    in_pay_d = in_pay_q;
    tag_d    = tag_q;
    len_d    = len_q;
    rem_d    = rem_q;
    sec_d    = sec_q;
    tag_base = (pos_q == '0) ? 32'd0 : tag_q;
    len_base = (pos_q == '0) ? 32'd0 : len_q;

    word_o                = '0;
    word_o.byte_out       = word_i.data_byte;
    word_o.section_number = sec_q;
    word_o.stream_end     = word_i.last_byte;
    word_o.status         = StatusOk;

    if (in_pay_q) begin
      word_o.is_payload     = 1'b1;
      word_o.section_tag    = tag_q;
      word_o.payload_length = len_q;
      word_o.payload_offset = len_q - rem_q;
      if (rem_q != '0) begin
        rem_d = rem_q - 32'd1;
      end
      if (rem_d == '0) begin
        word_o.section_end = 1'b1;
        in_pay_d           = 1'b0;
        sec_d              = sec_next;
      end
    end else begin
      tag_d = tag_base;
      len_d = len_base;
      if (32'(pos_q) < FieldBytes) begin
        tag_d[lane_sel +: 8] = word_i.data_byte;
      end else begin
        len_d[lane_sel +: 8] = word_i.data_byte;
      end
      if (32'(pos_q) == HeaderBytes - 1) begin
        pos_d                 = '0;
        word_o.header_done    = 1'b1;
        word_o.section_tag    = tag_d;
        word_o.payload_length = len_d;
        if (len_d == '0) begin
          word_o.section_end = 1'b1;
          sec_d              = sec_next;
        end else begin
          in_pay_d = 1'b1;
          rem_d    = len_d;
        end
      end else begin
        pos_d = pos_q + PosWidth'(1);
      end
    end

    // Stream end: report and start over
    if (word_i.last_byte) begin
      if (in_pay_d) begin
        word_o.status = StatusPayloadOver;
      end else if (pos_d != '0) begin
        word_o.status = StatusTruncHeader;
      end
      pos_d    = '0;
      in_pay_d = 1'b0;
      tag_d    = '0;
      len_d    = '0;
      rem_d    = '0;
      sec_d    = '0;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      in_pay_q <= 1'b0;
      tag_q    <= '0;
      len_q    <= '0;
      rem_q    <= '0;
      sec_q    <= '0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      in_pay_q <= in_pay_d;
      tag_q    <= tag_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
      sec_q    <= sec_d;
    end
  end

endmodule

FILE: hw/rtl/tag_length_chunk_deframer.sv
// Top level of the tag-length chunk deframer: input register, parser, result register.
//
//   port    dir  what one word carries
//   in_i    in   data_byte, last_byte (one raw stream byte)
//   out_o   out  byte_out plus role, tag, length, offset, section and status labels
//
// One byte per cycle sustained while out_o is ready; an accepted word is offered on out_o
// once it has passed the input register, then the result register.
// The parser state advances only when the input register hands its word to the
// result register, so stalls on the output hold everything in place while the
// input register still takes one more word.
// Reset (rst_ni low, asynchronous) empties both registers and clears the parser.
module tag_length_chunk_deframer import tlcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tlcd_in_if.sink    in_i,
  tlcd_out_if.source out_o
);

  logic      in_vld_q;
  in_word_t  in_word_q;
  logic      out_vld_q;
  out_word_t out_word_q;
  out_word_t res_word;
  logic      step;

  // Word moves from input register to result register
  assign step       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_word_q.data_byte <= in_i.data_byte;
      in_word_q.last_byte <= in_i.last_byte;
    end
  end

  tlcd_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .word_i (in_word_q),
    .word_o (res_word)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_word_q <= res_word;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.byte_out       = out_word_q.byte_out;
  assign out_o.is_payload     = out_word_q.is_payload;
  assign out_o.section_tag    = out_word_q.section_tag;
  assign out_o.payload_length = out_word_q.payload_length;
  assign out_o.payload_offset = out_word_q.payload_offset;
  assign out_o.header_done    = out_word_q.header_done;
  assign out_o.section_end    = out_word_q.section_end;
  assign out_o.section_number = out_word_q.section_number;
  assign out_o.stream_end     = out_word_q.stream_end;
  assign out_o.status         = out_word_q.status;

endmodule

FILE: tb/sv/tag_length_chunk_deframer_checker.sv
// Checker for the deframer: predicts the label of every byte and compares output words.
module tag_length_chunk_deframer_checker import tlcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tlcd_in_if   in_mon,
  tlcd_out_if  out_mon,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow parser state
  logic [PosWidth-1:0] hdr_pos  = '0;
  logic                in_pay   = 1'b0;
  logic [31:0]         tag_acc  = '0;
  logic [31:0]         len_acc  = '0;
  logic [31:0]         pay_left = '0;
  logic [31:0]         sec_idx  = '0;

  out_word_t label_q[$];
  int        fails = 0;

  assign fail_count_o = fails;

  function automatic void clear_parser();
    hdr_pos  = '0;
    in_pay   = 1'b0;
    tag_acc  = '0;
    len_acc  = '0;
    pay_left = '0;
    sec_idx  = '0;
  endfunction

  // Section index saturates at all ones (needs 2^32 sections, not reached here)
  function automatic void bump_section();
    if (sec_idx != '1) sec_idx++;
  endfunction

  // Expected label of one input byte; advances the shadow state
  function automatic out_word_t label_byte(in_word_t w);
    out_word_t o;
    o = '0;
    o.byte_out       = w.data_byte;
    o.section_number = sec_idx;
    o.stream_end     = w.last_byte;
    o.status         = StatusOk;
    if (in_pay) begin
      o.is_payload     = 1'b1;
      o.section_tag    = tag_acc;
      o.payload_length = len_acc;
      o.payload_offset = len_acc - pay_left;
      if (pay_left != 0) pay_left--;
      if (pay_left == 0) begin
        o.section_end = 1'b1;
        in_pay        = 1'b0;
        bump_section();
      end
    end else begin
      if (hdr_pos == 0) begin
        tag_acc = '0;
        len_acc = '0;
      end
      // Little-endian assembly: tag bytes first, then length bytes
      if (hdr_pos < FieldBytes) tag_acc[8*hdr_pos +: 8] = w.data_byte;
      else len_acc[8*(hdr_pos - FieldBytes) +: 8] = w.data_byte;
      if (hdr_pos == HeaderBytes - 1) begin
        hdr_pos          = '0;
        o.header_done    = 1'b1;
        o.section_tag    = tag_acc;
        o.payload_length = len_acc;
        if (len_acc == 0) begin
          // empty payload: the header byte also closes the section
          o.section_end = 1'b1;
          bump_section();
        end else begin
          in_pay   = 1'b1;
          pay_left = len_acc;
        end
      end else begin
        hdr_pos = hdr_pos + 1'b1;
      end
    end
    // End of stream: report leftovers, then start over
    if (w.last_byte) begin
      if (in_pay) o.status = StatusPayloadOver;
      else if (hdr_pos != 0) o.status = StatusTruncHeader;
      clear_parser();
    end
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
      fails++;
    end
  endfunction

  function automatic void compare_word(out_word_t want);
    check_field("byte_out", 32'(want.byte_out), 32'(out_mon.byte_out));
    check_field("is_payload", 32'(want.is_payload), 32'(out_mon.is_payload));
    check_field("section_tag", want.section_tag, out_mon.section_tag);
    check_field("payload_length", want.payload_length, out_mon.payload_length);
    check_field("payload_offset", want.payload_offset, out_mon.payload_offset);
    check_field("header_done", 32'(want.header_done), 32'(out_mon.header_done));
    check_field("section_end", 32'(want.section_end), 32'(out_mon.section_end));
    check_field("section_number", want.section_number, out_mon.section_number);
    check_field("stream_end", 32'(want.stream_end), 32'(out_mon.stream_end));
    check_field("status", 32'(want.status), 32'(out_mon.status));
  endfunction

  // Output side first: a word leaving now cannot be the one entering now
  always @(posedge clk_i or negedge rst_ni) begin
    in_word_t w;
    if (!rst_ni) begin
      clear_parser();
      label_q.delete();
      pending_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (label_q.size() == 0) begin
          $display("%0t: unexpected output word, expected none, actual byte %h",
                   $realtime, out_mon.byte_out);
          fails++;
        end else begin
          compare_word(label_q.pop_front());
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        w.data_byte = in_mon.data_byte;
        w.last_byte = in_mon.last_byte;
        label_q.insert(label_q.size(), label_byte(w));
      end
      pending_o <= label_q.size();
    end
  end

endmodule

FILE: tb/sv/tag_length_chunk_deframer_test.sv
// Testbench top for the deframer: stream stimulus, handshake pacing and the verdict.
module tag_length_chunk_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tlcd_pkg::*;

  localparam int RandomItems = 450;
  localparam int IdlePct     = 32;
  localparam int CalmFirst   = 200;
  localparam int CalmLast    = 320;
  localparam int HoldAt      = 250;
  localparam int HoldCycles  = 120;
  localparam int DrainCycles = 10;
  localparam int CycleLimit  = 200000;

  typedef enum int {KindClean, KindCutHeader, KindCutPayload, KindNoise} stream_kind_e;

  logic clk_i;
  logic rst_ni;
  logic calm;
  int   chk_fails;
  int   chk_pending;

  tlcd_in_if  byte_if();
  tlcd_out_if label_if();

  tag_length_chunk_deframer DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_if),
    .out_o (label_if)
  );

  tag_length_chunk_deframer_checker label_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (byte_if),
    .out_mon     (label_if),
    .fail_count_o(chk_fails),
    .pending_o   (chk_pending)
  );

  in_word_t byte_q[$];

  function automatic void push_byte(logic [7:0] b);
    in_word_t w;
    w.data_byte = b;
    w.last_byte = 1'b0;
    byte_q.insert(byte_q.size(), w);
  endfunction

  function automatic void push_header(logic [31:0] tag, logic [31:0] len);
    for (int k = 0; k < 4; k++) push_byte(tag[8*k +: 8]);
    for (int k = 0; k < 4; k++) push_byte(len[8*k +: 8]);
  endfunction

  function automatic void push_section(logic [31:0] tag, logic [31:0] len);
    push_header(tag, len);
    repeat (len) push_byte(8'($urandom));
  endfunction

  function automatic void mark_last();
    in_word_t w;
    w = byte_q.pop_back();
    w.last_byte = 1'b1;
    byte_q.insert(byte_q.size(), w);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    int n;
    n = 0;
    while (n < CycleLimit) begin
      @(posedge clk_i);
      n++;
    end
    $display("tag_length_chunk_deframer_test NOT OK");
    $finish;
  end

  // Receiver: random stalls, calm stretch, one long hold-off
  initial begin
    int cyc;
    int hold;
    cyc  = 0;
    hold = 0;
    label_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc == HoldAt) hold = HoldCycles;
      if (hold > 0) begin
        hold--;
        label_if.ready <= 1'b0;
      end else begin
        label_if.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int           n_directed;
    int           pick;
    int           nsec;
    logic [31:0]  len;
    stream_kind_e kind;

    rst_ni            <= 1'b0;
    calm              <= 1'b0;
    byte_if.valid     <= 1'b0;
    byte_if.data_byte <= 8'h00;
    byte_if.last_byte <= 1'b0;

    // Directed streams
    push_byte(8'hFF);                       // lone byte: truncated header
    mark_last();
    push_header(32'hFFFF_FFFF, 32'h0);      // empty payload, clean end
    mark_last();
    push_header(32'h0000_0000, 32'hFFFF_FFFF);
    push_byte(8'h00);                       // payload cut short by stream end
    push_byte(8'hFF);
    mark_last();
    push_header(32'h1234_5678, 32'h1);      // header completes on the last byte
    mark_last();
    n_directed = byte_q.size();

    // Random streams: mostly well formed, some cut short, some noise
    while (byte_q.size() < n_directed + RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) kind = KindClean;
      else if (pick < 75) kind = KindCutHeader;
      else if (pick < 90) kind = KindCutPayload;
      else kind = KindNoise;
      if (kind == KindClean) nsec = $urandom_range(1, 4);
      else if (kind == KindNoise) nsec = 0;
      else nsec = $urandom_range(0, 2);
      for (int s = 0; s < nsec; s++) begin
        len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 40);
        push_section($urandom, len);
      end
      case (kind)
        KindCutHeader: repeat ($urandom_range(1, 7)) push_byte(8'($urandom));
        KindCutPayload: begin
          len = $urandom_range(0, 1) ? $urandom_range(2, 8) : $urandom;
          if (len == 0) len = 1;
          push_header($urandom, len);
          repeat ($urandom_range(0, (len > 6) ? 6 : len - 1)) push_byte(8'($urandom));
        end
        KindNoise: repeat ($urandom_range(1, 24)) push_byte(8'($urandom));
        default: ;
      endcase
      mark_last();
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < byte_q.size(); i++) begin
      // Let the directed part drain completely before random traffic
      if (i == n_directed) begin
        byte_if.valid <= 1'b0;
        @(posedge clk_i);
        while (chk_pending != 0) @(posedge clk_i);
      end
      while (!calm && $urandom_range(0, 99) < IdlePct) begin
        byte_if.valid <= 1'b0;
        @(posedge clk_i);
      end
      calm              <= (i >= CalmFirst && i < CalmLast);
      byte_if.valid     <= 1'b1;
      byte_if.data_byte <= byte_q[i].data_byte;
      byte_if.last_byte <= byte_q[i].last_byte;
      @(posedge clk_i);
      while (!byte_if.ready) @(posedge clk_i);
    end
    byte_if.valid <= 1'b0;

    // Drain
    @(posedge clk_i);
    while (chk_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (chk_fails == 0) $display("tag_length_chunk_deframer_test OK");
    else $display("tag_length_chunk_deframer_test NOT OK");
    $finish;
  end

endmodule
